// File: rtl/lcd_glyph_byte_generator_unit_assert.svh
// Assertion macros for the checker file of the LCD glyph byte generator.
// No dependencies; files that assert take this header by include.
`ifndef LCD_GLYPH_BYTE_GENERATOR_UNIT_ASSERT_SVH
`define LCD_GLYPH_BYTE_GENERATOR_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lgb_pkg.sv
// Package of the LCD glyph byte generator: request and result types, command
// constants, run lengths and the font and glyph tables. No dependencies.
package lgb_pkg;

    localparam int IDX_W = 5;

    // Request type codes.
    localparam logic [1:0] REQ_ASCII = 2'd0;
    localparam logic [1:0] REQ_GLYPH = 2'd1;
    localparam logic [1:0] REQ_POS   = 2'd2;

    localparam logic [IDX_W-1:0] ASCII_LEN      = 5'd5;
    localparam logic [IDX_W-1:0] GLYPH_LEN      = 5'd30;
    localparam logic [IDX_W-1:0] POS_LEN        = 5'd3;
    localparam logic [IDX_W-1:0] GLYPH_HALF_LEN = 5'd15;
    localparam logic [3:0]       ADDR_CMDS      = 4'd3;

    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] ASCII_FIRST = 8'd32;
    localparam logic [3:0] GLYPH_BANK  = 4'h3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic       invert;
        logic [3:0] page_row;
        logic [7:0] column_pos;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_byte;
        logic       bad_code;
    } t_res;

    // Request held by the sequencer and the byte of its run now due.
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
        t_req             req;
    } t_slot;

    function automatic logic [IDX_W-1:0] run_len(input logic [1:0] req_type);
        logic [IDX_W-1:0] len;
        unique case (req_type)
            REQ_ASCII: len = ASCII_LEN;
            REQ_GLYPH: len = GLYPH_LEN;
            REQ_POS:   len = POS_LEN;
            default:   len = '0;
        endcase
        return len;
    endfunction

    // 5x8 font, one row per character from space upward, column 0 in the top byte.
    localparam logic [39:0] FONT_ROM [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242E7B2A12, 40'h2313086462, 40'h3649562050, 40'h0004030100,
        40'h001C224100, 40'h0041221C00, 40'h22147F1422, 40'h08087F0808,
        40'h4030100000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h6251494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h0171090503,
        40'h3649494936, 40'h464949291E, 40'h0036360000, 40'h4036360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201590502,
        40'h3E415D555E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41515172,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h7F7F414100,
        40'h0204081020, 40'h0041417F7F, 40'h04027F0204, 40'h081C2A0808,
        40'h0000010204, 40'h2454543840, 40'h7F28444438, 40'h3844444408,
        40'h384444287F, 40'h3854545408, 40'h087E090902, 40'h98A4A4A478,
        40'h7F08040478, 40'h0000790000, 40'h0080887900, 40'h7F10284440,
        40'h00417F4000, 40'h7804780478, 40'h0478040478, 40'h3844444438,
        40'hFC24242418, 40'h18242424FC, 40'h0478040408, 40'h4854545424,
        40'h043F444424, 40'h3C40403C40, 40'h1C2040201C, 40'h3C403C403C,
        40'h4428102844, 40'h9CA0A0907C, 40'h4464544C44, 40'h0836410000,
        40'h0000770000, 40'h0000413608, 40'h0609090600, 40'h0804081008
    };

    // 12x16 glyphs: upper page then lower page, column 0 in the top byte.
    localparam logic [95:0] GLYPH_ROM [16][2] = '{
        '{96'h00FE1222C2221A02FE000000, 96'h080702010001020003040F00},
        '{96'h8868FF2840FE12F212917100, 96'h00000F080403080502050800},
        '{96'h88FF48004CA4958694A44C00, 96'h080F00000808080F08080800},
        '{96'h18D654FF54D410FC0000FF00, 96'h0007000F0407000108080F00},
        '{96'h008292DAD6B2B19189C18000, 96'h08040200080F000002040900},
        '{96'h98D4B3880064D44DC654E400, 96'h040402020804030007080C00},
        '{96'h8282FFAAAAAAAAAAFF828200, 96'h0A090A0A0A0F0A0A0A090A00},
        '{96'h42F22E22E200BC20FF20BC00, 96'h000702020700070407040F00},
        '{96'h8888FF48085F55D5555F4000, 96'h00080F000807080F09090800},
        '{96'h8282BAAAAAABAAAABA828200, 96'h0F00000E0A0A0A0E00080F00},
        '{96'h08F4535252F25A5650F00000, 96'h0807010101070101090F0000},
        '{96'h00FE0A8ABEAAABAABE8A0A00, 96'h08070008090A04040A090800},
        '{96'h1011F20050CF41414FD01000, 96'h000007020808050205080800},
        '{96'h1017D555577D5755D5171000, 96'h08080F08080E08080F080800},
        '{96'h404242FE424242FE42424000, 96'h000806010000000F00000000},
        '{96'h88780FF800D8545350D83000, 96'h0805020D000F0404040F0000}
    };

endpackage

// File: rtl/lgb_seq.sv
// Request register and byte counter of the LCD glyph byte generator.
// Depends on lgb_pkg.
module lgb_seq
    import lgb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_req  i_req,
    input  logic  i_out_free,
    output t_slot o_slot
);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_req             r_req;

    logic step;
    logic last;
    logic accept;

    assign step   = r_busy && i_out_free;
    assign last   = (r_idx == run_len(r_req.req_type) - 5'd1);
    // The next request is taken in the cycle the last byte of this one leaves.
    assign o_req_ready = !r_busy || (step && last);
    assign accept      = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (accept) begin
            // An unused request type produces no bytes.
            r_busy <= (run_len(i_req.req_type) != '0);
            r_idx  <= '0;
        end else if (step) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_slot = '{busy: r_busy, idx: r_idx, req: r_req};

endmodule

// File: rtl/lgb_fmt.sv
// Byte former of the LCD glyph byte generator: address commands and table lookups
// for one byte of a request's run. Depends on lgb_pkg.
module lgb_fmt
    import lgb_pkg::*;
(
    input  t_req             i_req,
    input  logic [IDX_W-1:0] i_idx,
    output t_res             o_res
);

    logic             ascii_ok;
    logic             glyph_ok;
    logic             half;
    logic [IDX_W-1:0] pos_full;
    logic [3:0]       pos;
    logic [3:0]       col;
    logic [6:0]       font_idx;
    logic [39:0]      font_row;
    logic [95:0]      glyph_row;
    logic [3:0]       page0;
    logic [7:0]       col0;
    logic [7:0]       mask;
    logic [7:0]       addr_byte;
    logic [7:0]       glyph_byte;

    always_comb begin
        ascii_ok = !i_req.char_code[7] && (i_req.char_code[6:5] != 2'b00);
        glyph_ok = (i_req.char_code[7:4] == GLYPH_BANK);
        mask     = {8{i_req.invert}};

        // A glyph run is two halves of three commands and twelve columns.
        half     = (i_req.req_type == REQ_GLYPH) && (i_idx >= GLYPH_HALF_LEN);
        pos_full = half ? i_idx - GLYPH_HALF_LEN : i_idx;
        pos      = pos_full[3:0];
        col      = (pos >= ADDR_CMDS) ? pos - ADDR_CMDS : 4'd0;

        font_idx  = ascii_ok ? i_req.char_code[6:0] - ASCII_FIRST[6:0] : 7'd0;
        font_row  = FONT_ROM[font_idx];
        glyph_row = GLYPH_ROM[i_req.char_code[3:0]][half];
        glyph_byte = glyph_ok ? glyph_row[7'd95 - {col, 3'b000} -: 8] : 8'h00;

        page0 = i_req.page_row - 4'd1 + {3'b000, half};
        col0  = i_req.column_pos - 8'd1;
        unique case (pos[1:0])
            2'd0:    addr_byte = CMD_PAGE | {4'h0, page0};
            2'd1:    addr_byte = CMD_COL_HI | {4'h0, col0[7:4]};
            default: addr_byte = {4'h0, col0[3:0]};
        endcase

        o_res           = '0;
        o_res.last_byte = (i_idx == run_len(i_req.req_type) - 5'd1);
        unique case (i_req.req_type)
            REQ_ASCII: begin
                o_res.out_byte = (ascii_ok ? font_row[6'd39 - {i_idx[2:0], 3'b000} -: 8]
                                           : 8'h00) ^ mask;
                o_res.is_data  = 1'b1;
                o_res.bad_code = !ascii_ok;
            end
            REQ_GLYPH: begin
                if (pos < ADDR_CMDS) begin
                    o_res.out_byte = addr_byte;
                end else begin
                    o_res.out_byte = glyph_byte ^ mask;
                    o_res.is_data  = 1'b1;
                end
                o_res.bad_code = !glyph_ok;
            end
            REQ_POS: begin
                o_res.out_byte = addr_byte;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// File: rtl/lcd_glyph_byte_generator_unit.sv
// Top level of the LCD glyph byte generator: sequencer, byte former and output
// register. Depends on lgb_pkg, lgb_seq and lgb_fmt.
//
// Use: a request (i_req, accepted when i_req_valid and o_req_ready are high)
// asks for a character, a wide glyph or a cursor position. The block answers
// with a run of controller bytes on o_res (taken when o_res_valid and
// i_res_ready are high), one byte per cycle while the receiver takes them,
// last_byte set on the final one. Run lengths: ASCII 5 bytes, glyph 30 bytes,
// position 3 bytes; request type 3 is accepted and gives no bytes.
// The request is held in the sequencer register and each byte passes through
// the single output register on its way to o_res. The next request is
// accepted in the cycle the last byte of the current run moves into the output
// register. Reset (synchronous, active low) empties the output register and
// drops any request in progress. When the receiver stalls, the output byte
// holds and the run pauses; no byte is lost or repeated.
module lcd_glyph_byte_generator_unit
    import lgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    t_slot slot;
    t_res  fmt_res;
    logic  out_free;
    logic  step;
    logic  r_out_valid;
    t_res  r_out;

    assign out_free = !r_out_valid || i_res_ready;
    assign step     = slot.busy && out_free;

    lgb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_out_free  (out_free),
        .o_slot      (slot)
    );

    lgb_fmt u_fmt (
        .i_req (slot.req),
        .i_idx (slot.idx),
        .o_res (fmt_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= fmt_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: rtl/lgb_chk.sv
// Port checker for the LCD glyph byte generator, bound to the top level.
// Depends on lgb_pkg and lcd_glyph_byte_generator_unit_assert.svh.
`include "lcd_glyph_byte_generator_unit_assert.svh"

module lgb_chk
    import lgb_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_res_valid,
    input logic i_res_ready,
    input t_res o_res
);

    // A stalled result keeps its byte and flags.
    `LGB_ASSERT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res), "stalled result changed")

    // Nothing is offered in the cycle after reset.
    `LGB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_res_valid, "result valid after reset")

    // A run that ends on a command ends on the low column nibble.
    `LGB_ASSERT(a_cmd_last, i_clk, i_rst_n, o_res_valid && !o_res.is_data && o_res.last_byte |-> o_res.out_byte[7:4] == 4'h0, "run ended on a command other than low column")

    // A page command always has more bytes after it.
    `LGB_ASSERT(a_page_not_last, i_clk, i_rst_n, o_res_valid && !o_res.is_data && o_res.out_byte[7:4] == CMD_PAGE[7:4] |-> !o_res.last_byte, "page command marked last")

endmodule

bind lcd_glyph_byte_generator_unit lgb_chk u_chk (.*);
